// ===== sv/wee_pkg.sv =====
// Shared types, constants and helpers for the weight-of-evidence encoder.
// No dependencies; wee_log2 and the top level use this package by scoped name.
package wee_pkg;

    localparam int NUM_COLUMNS    = 4;
    localparam int NUM_CATEGORIES = 256;
    localparam int COUNT_BITS     = 32;
    localparam int TABLE_SIZE     = NUM_COLUMNS * NUM_CATEGORIES;
    localparam int ADDR_W         = $clog2(TABLE_SIZE);

    localparam int EPS_W    = 16;
    localparam int VAL_W    = 24;
    localparam int TERM_W   = 65;            // count*2^16 + k*eps, with carry
    localparam int LOG_FRAC = 24;
    localparam int EXP_W    = 7;             // MSB position 0..64
    localparam int LOG_W    = EXP_W + LOG_FRAC;
    localparam int ACC_W    = LOG_W + 3;     // signed sum of four logs
    localparam int MAG_W    = ACC_W - 1;
    localparam int PROD_W   = MAG_W + 32;

    localparam logic [31:0]          LN2_Q32  = 32'd2977044472;
    localparam logic [PROD_W:0]      RND_HALF = (PROD_W + 1)'(1) << 39;
    localparam logic [VAL_W-1:0]     OUT_MAX  = 24'h7FFFFF;
    localparam logic [VAL_W-1:0]     OUT_MIN  = 24'h800000;
    localparam logic [EPS_W-1:0]     EPS_RESET = 16'd32768;

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_TRAIN     = 2'd1,
        OP_TRANSFORM = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic {
        REG_EPSILON = 1'b0,
        REG_DEFAULT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              start;
        logic [TERM_W-1:0] value;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] result;
    } log_rsp_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQUARE
    } log_state_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TRAIN_WB,
        ST_XF_CHECK,
        ST_LOG_START,
        ST_LOG_WAIT,
        ST_SCALE,
        ST_ROUND,
        ST_DONE
    } state_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + COUNT_BITS'(1);
    endfunction

endpackage

// ===== sv/wee_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/wee_log2.sv =====
// Iterative log2 unit, Q.24 result: binary-search normalize, then one
// squaring per fraction bit. Depends on wee_pkg.
module wee_log2 (
    input  logic              clk,
    input  logic              rst_n,
    input  wee_pkg::log_req_t req,
    output wee_pkg::log_rsp_t rsp
);

    wee_pkg::log_state_t              state_reg, state_next;
    logic [wee_pkg::TERM_W-1:0]       v_reg, v_next;
    logic [wee_pkg::EXP_W-1:0]        exp_reg, exp_next;
    logic [2:0]                       step_reg, step_next;
    logic [31:0]                      y_reg, y_next;
    logic [wee_pkg::LOG_FRAC-1:0]     frac_reg, frac_next;
    logic [4:0]                       bit_reg, bit_next;
    logic                             done_reg, done_next;
    logic [63:0]                      sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wee_pkg::LG_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        exp_reg  <= exp_next;
        step_reg <= step_next;
        y_reg    <= y_next;
        frac_reg <= frac_next;
        bit_reg  <= bit_next;
    end

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        exp_next   = exp_reg;
        step_next  = step_reg;
        y_next     = y_reg;
        frac_next  = frac_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        sq         = y_reg * y_reg;

        case (state_reg)
            wee_pkg::LG_IDLE:
            begin
                if (req.start)
                begin
                    v_next     = req.value;
                    exp_next   = 7'd64;
                    step_next  = 3'd0;
                    frac_next  = '0;
                    state_next = wee_pkg::LG_NORM;
                end
            end
            wee_pkg::LG_NORM:
            begin
                // shift by 32, 16, 8, 4, 2, 1, 1 while the top bits are clear;
                // the last single shift covers a value of 1 (MSB at bit 0)
                case (step_reg)
                    3'd0:
                    begin
                        if (v_reg[64 -: 32] == '0)
                        begin
                            v_next   = v_reg << 32;
                            exp_next = exp_reg - 7'd32;
                        end
                    end
                    3'd1:
                    begin
                        if (v_reg[64 -: 16] == '0)
                        begin
                            v_next   = v_reg << 16;
                            exp_next = exp_reg - 7'd16;
                        end
                    end
                    3'd2:
                    begin
                        if (v_reg[64 -: 8] == '0)
                        begin
                            v_next   = v_reg << 8;
                            exp_next = exp_reg - 7'd8;
                        end
                    end
                    3'd3:
                    begin
                        if (v_reg[64 -: 4] == '0)
                        begin
                            v_next   = v_reg << 4;
                            exp_next = exp_reg - 7'd4;
                        end
                    end
                    3'd4:
                    begin
                        if (v_reg[64 -: 2] == '0)
                        begin
                            v_next   = v_reg << 2;
                            exp_next = exp_reg - 7'd2;
                        end
                    end
                    default:
                    begin
                        if (!v_reg[64])
                        begin
                            v_next   = v_reg << 1;
                            exp_next = exp_reg - 7'd1;
                        end
                    end
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    y_next     = v_next[64:33];
                    bit_next   = 5'(wee_pkg::LOG_FRAC - 1);
                    state_next = wee_pkg::LG_SQUARE;
                end
            end
            wee_pkg::LG_SQUARE:
            begin
                if (sq[63])
                begin
                    frac_next[bit_reg] = 1'b1;
                    y_next             = sq[63:32];
                end
                else
                begin
                    y_next = sq[62:31];
                end
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    done_next  = 1'b1;
                    state_next = wee_pkg::LG_IDLE;
                end
            end
            default:
            begin
                state_next = wee_pkg::LG_IDLE;
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.result = {exp_reg, frac_reg};

endmodule

// ===== sv/weight_of_evidence_encoder.sv =====
// Top level of the weight-of-evidence encoder: count RAM, control FSM, output register.
// Depends on wee_pkg, wee_ram and wee_log2.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | operation, column, category, target
//  out     | out_valid / out_stall| encoded_value, in_range, error
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One item at a time. Train: accept, RAM read, write-back, result;
// accept, then result when the category is out of range.
// Transform goes through the shared log2 unit once for each of four terms
// (start, 7 normalize steps, 24 squarings, handoff per term). Transform with
// zero totals or out-of-range category, and no-op items: accept, then result.
// Clear: one RAM word zeroed per cycle over the whole table, then result.
// After reset the same sweep runs with in_stall high.
// A finished result sits in the output register; the next item is taken
// while it waits, and a new result holds in ST_DONE until that register frees.
module weight_of_evidence_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic [1:0]                          column,
    input  logic [15:0]                         category,
    input  logic                                target,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [wee_pkg::VAL_W-1:0]    encoded_value,
    output logic                                in_range,
    output logic                                error,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [wee_pkg::VAL_W-1:0]           cfg_data
);

    localparam int CB = wee_pkg::COUNT_BITS;

    wee_pkg::state_t                 state_reg, state_next;
    wee_pkg::op_t                    op_reg, op_next;
    logic                            tgt_reg, tgt_next;
    logic                            ok_reg, ok_next;
    logic [wee_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [CB-1:0]                   tot_pos_reg, tot_pos_next;
    logic [CB-1:0]                   tot_neg_reg, tot_neg_next;
    logic [wee_pkg::EPS_W-1:0]       eps_reg, eps_next;
    logic [wee_pkg::VAL_W-1:0]       dflt_reg, dflt_next;
    logic [wee_pkg::ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                            clr_reply_reg, clr_reply_next;
    logic [CB-1:0]                   pos_reg, pos_next;
    logic [CB-1:0]                   neg_reg, neg_next;
    logic [1:0]                      term_reg, term_next;
    logic signed [wee_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [wee_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [wee_pkg::VAL_W-1:0]       val_reg, val_next;
    logic                            err_reg, err_next;
    logic                            out_valid_reg, out_valid_next;
    logic [wee_pkg::VAL_W-1:0]       out_val_reg, out_val_next;
    logic                            out_range_reg, out_range_next;
    logic                            out_err_reg, out_err_next;

    // RAM word: {positive count, negative count}
    logic                            ram_we, ram_re;
    logic [wee_pkg::ADDR_W-1:0]      ram_waddr;
    logic [2*CB-1:0]                 ram_wdata, ram_rdata;

    wee_pkg::log_req_t               log_req;
    wee_pkg::log_rsp_t               log_rsp;

    logic                            accept;
    logic                            in_ok;
    logic [CB-1:0]                   rd_pos, rd_neg;
    logic [CB:0]                     pair_sum;
    logic [CB-1:0]                   term_cnt;
    logic [wee_pkg::EPS_W:0]         term_add;
    logic [wee_pkg::MAG_W-1:0]       mag;
    logic [wee_pkg::PROD_W:0]        rsum;
    logic [wee_pkg::PROD_W-40:0]     rnd;
    logic [wee_pkg::VAL_W-1:0]       rnd_lo;
    logic signed [wee_pkg::ACC_W-1:0] log_ext;

    wee_ram #(
        .WIDTH (2 * CB),
        .DEPTH (wee_pkg::TABLE_SIZE)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    wee_log2 u_log2 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    assign in_stall      = (state_reg != wee_pkg::ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign encoded_value = out_val_reg;
    assign in_range      = out_range_reg;
    assign error         = out_err_reg;

    assign in_ok = (int'(column) < wee_pkg::NUM_COLUMNS)
                && (int'(category) < wee_pkg::NUM_CATEGORIES);

    assign rd_pos   = ram_rdata[2*CB-1:CB];
    assign rd_neg   = ram_rdata[CB-1:0];
    assign pair_sum = {1'b0, rd_pos} + {1'b0, rd_neg};

    // log terms in order: +lg(p), -lg(P), -lg(n), +lg(N); totals take 2*eps
    always_comb
    begin
        case (term_reg)
            2'd0:    term_cnt = pos_reg;
            2'd1:    term_cnt = tot_pos_reg;
            2'd2:    term_cnt = neg_reg;
            default: term_cnt = tot_neg_reg;
        endcase
        term_add      = term_reg[0] ? {eps_reg, 1'b0} : {1'b0, eps_reg};
        log_req.start = (state_reg == wee_pkg::ST_LOG_START);
        log_req.value = (wee_pkg::TERM_W'(term_cnt) << 16) + wee_pkg::TERM_W'(term_add);
    end

    assign log_ext       = wee_pkg::ACC_W'(log_rsp.result);

    assign mag    = acc_reg[wee_pkg::ACC_W-1] ? wee_pkg::MAG_W'(-acc_reg)
                                              : wee_pkg::MAG_W'(acc_reg);
    assign rsum   = {1'b0, prod_reg} + wee_pkg::RND_HALF;
    assign rnd    = rsum[wee_pkg::PROD_W:40];
    assign rnd_lo = rnd[wee_pkg::VAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wee_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            tot_pos_reg   <= '0;
            tot_neg_reg   <= '0;
            eps_reg       <= wee_pkg::EPS_RESET;
            dflt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            tot_pos_reg   <= tot_pos_next;
            tot_neg_reg   <= tot_neg_next;
            eps_reg       <= eps_next;
            dflt_reg      <= dflt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tgt_reg       <= tgt_next;
        ok_reg        <= ok_next;
        addr_reg      <= addr_next;
        pos_reg       <= pos_next;
        neg_reg       <= neg_next;
        term_reg      <= term_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        val_reg       <= val_next;
        err_reg       <= err_next;
        out_val_reg   <= out_val_next;
        out_range_reg <= out_range_next;
        out_err_reg   <= out_err_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        tgt_next       = tgt_reg;
        ok_next        = ok_reg;
        addr_next      = addr_reg;
        tot_pos_next   = tot_pos_reg;
        tot_neg_next   = tot_neg_reg;
        eps_next       = eps_reg;
        dflt_next      = dflt_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        out_val_next   = out_val_reg;
        out_range_next = out_range_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = '0;

        if (cfg_valid)
        begin
            case (wee_pkg::reg_idx_t'(cfg_index))
                wee_pkg::REG_EPSILON: eps_next  = cfg_data[wee_pkg::EPS_W-1:0];
                wee_pkg::REG_DEFAULT: dflt_next = cfg_data;
                default:              eps_next  = eps_reg;
            endcase
        end

        case (state_reg)
            wee_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + wee_pkg::ADDR_W'(1);
                if (clr_cnt_reg == wee_pkg::ADDR_W'(wee_pkg::TABLE_SIZE - 1))
                begin
                    state_next = clr_reply_reg ? wee_pkg::ST_DONE : wee_pkg::ST_IDLE;
                end
            end
            wee_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = wee_pkg::op_t'(operation);
                    tgt_next  = target;
                    ok_next   = in_ok;
                    addr_next = in_ok ? wee_pkg::ADDR_W'(int'(column) * wee_pkg::NUM_CATEGORIES
                                                         + int'(category))
                                      : '0;
                    val_next  = '0;
                    err_next  = 1'b0;
                    case (wee_pkg::op_t'(operation))
                        wee_pkg::OP_CLEAR:
                        begin
                            tot_pos_next   = '0;
                            tot_neg_next   = '0;
                            clr_cnt_next   = '0;
                            clr_reply_next = 1'b1;
                            state_next     = wee_pkg::ST_CLEAR;
                        end
                        wee_pkg::OP_TRAIN:
                        begin
                            // totals move on column 0 even when the category is out of range
                            if (column == 2'd0)
                            begin
                                if (target)
                                    tot_pos_next = wee_pkg::sat_inc(tot_pos_reg);
                                else
                                    tot_neg_next = wee_pkg::sat_inc(tot_neg_reg);
                            end
                            state_next = in_ok ? wee_pkg::ST_READ : wee_pkg::ST_DONE;
                        end
                        wee_pkg::OP_TRANSFORM:
                        begin
                            if (tot_pos_reg == '0 || tot_neg_reg == '0)
                            begin
                                err_next   = 1'b1;
                                val_next   = dflt_reg;
                                state_next = wee_pkg::ST_DONE;
                            end
                            else if (!in_ok)
                            begin
                                val_next   = dflt_reg;
                                state_next = wee_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = wee_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = wee_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            wee_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = (op_reg == wee_pkg::OP_TRAIN) ? wee_pkg::ST_TRAIN_WB
                                                           : wee_pkg::ST_XF_CHECK;
            end
            wee_pkg::ST_TRAIN_WB:
            begin
                ram_we     = 1'b1;
                ram_wdata  = tgt_reg ? {wee_pkg::sat_inc(rd_pos), rd_neg}
                                     : {rd_pos, wee_pkg::sat_inc(rd_neg)};
                state_next = wee_pkg::ST_DONE;
            end
            wee_pkg::ST_XF_CHECK:
            begin
                pos_next  = rd_pos;
                neg_next  = rd_neg;
                term_next = 2'd0;
                acc_next  = '0;
                if (pair_sum <= (CB + 1)'(1))
                begin
                    val_next   = dflt_reg;
                    state_next = wee_pkg::ST_DONE;
                end
                else if (rd_pos == '0 && eps_reg == '0)
                begin
                    val_next   = wee_pkg::OUT_MIN;
                    state_next = wee_pkg::ST_DONE;
                end
                else if (rd_neg == '0 && eps_reg == '0)
                begin
                    val_next   = wee_pkg::OUT_MAX;
                    state_next = wee_pkg::ST_DONE;
                end
                else
                begin
                    state_next = wee_pkg::ST_LOG_START;
                end
            end
            wee_pkg::ST_LOG_START:
            begin
                state_next = wee_pkg::ST_LOG_WAIT;
            end
            wee_pkg::ST_LOG_WAIT:
            begin
                if (log_rsp.done)
                begin
                    if (term_reg == 2'd0 || term_reg == 2'd3)
                        acc_next = acc_reg + log_ext;
                    else
                        acc_next = acc_reg - log_ext;
                    term_next  = term_reg + 2'd1;
                    state_next = (term_reg == 2'd3) ? wee_pkg::ST_SCALE
                                                    : wee_pkg::ST_LOG_START;
                end
            end
            wee_pkg::ST_SCALE:
            begin
                // log2 ratio times ln2 in Q.32
                prod_next  = mag * wee_pkg::LN2_Q32;
                state_next = wee_pkg::ST_ROUND;
            end
            wee_pkg::ST_ROUND:
            begin
                if (acc_reg[wee_pkg::ACC_W-1])
                    val_next = (rnd > 26'd8388608) ? wee_pkg::OUT_MIN : -rnd_lo;
                else
                    val_next = (rnd > 26'd8388607) ? wee_pkg::OUT_MAX : rnd_lo;
                state_next = wee_pkg::ST_DONE;
            end
            wee_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = val_reg;
                    out_range_next = ok_reg;
                    out_err_next   = err_reg;
                    clr_reply_next = 1'b0;
                    state_next     = wee_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wee_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
